>>> sv/ffe_pkg.sv
// ----------------------------------------------------------------------------
// ffe_pkg
// Shared types and constants of the form field extractor: the configuration
// register indexes and the command that the parser hands to the emitter.
// ----------------------------------------------------------------------------
package ffe_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE_LEN = 2'd2;

  // One parsed body byte: up to two decoded bytes and an optional done marker
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [1:0] n_bytes;
    logic       done;
    logic       found;
  } cmd_t;

  // Number of results a command expands into
  function automatic logic [1:0] cmd_len(cmd_t c);
    return c.n_bytes + {1'b0, c.done};
  endfunction

endpackage

>>> sv/ffe_body_if.sv
// ----------------------------------------------------------------------------
// ffe_body_if
// Valid/ready channel carrying raw form body bytes with a last-byte mark.
// ----------------------------------------------------------------------------
interface ffe_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_last;

  modport source (output valid, output body_byte, output body_last, input ready);
  modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

>>> sv/ffe_value_if.sv
// ----------------------------------------------------------------------------
// ffe_value_if
// Valid/ready channel carrying decoded value bytes and the end-of-body result.
// ----------------------------------------------------------------------------
interface ffe_value_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       value_done;
  logic       key_found;

  modport source (output valid, output value_byte, output value_done,
                  output key_found, input ready);
  modport sink   (input valid, input value_byte, input value_done,
                  input key_found, output ready);
endinterface

>>> sv/ffe_front.sv
// ----------------------------------------------------------------------------
// ffe_front
// Parser: holds the configuration, matches the key, URL-decodes the value and
// turns each accepted body byte that yields value bytes or ends the body into one command for the emitter.
// ----------------------------------------------------------------------------
module ffe_front #(
  parameter int unsigned KEY_BYTES = 8,
  parameter int unsigned MAX_VALUE = 511
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffe_body_if.sink                       body_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output ffe_pkg::cmd_t                  cmd_o
);

  localparam int unsigned KPW = $clog2(KEY_BYTES + 1);
  localparam int unsigned CW  = $clog2(MAX_VALUE + 1);
  localparam int unsigned LW  = (CW > 9) ? CW : 9;

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef enum logic [2:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_HEX1,
    PH_HEX2,
    PH_DONE
  } phase_e;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] plain(logic [7:0] c);
    return (c == CH_PLUS) ? CH_SP : c;
  endfunction

  logic [3:0]  key_len_q;
  logic [63:0] key_chars_q;
  logic [8:0]  max_len_q;

  phase_e         phase_q, phase_d;
  logic [KPW-1:0] kpos_q, kpos_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [7:0]     pend_q, pend_d;
  logic           seen_q, seen_d;

  logic          accept;
  logic [7:0]    b;
  logic          last;
  logic [3:0]    klen;
  logic [LW-1:0] lim;
  logic [LW:0]   cnt_inc;
  logic [7:0]    key_byte;
  logic [4:0]    hi, lo;
  logic [7:0]    decoded;
  logic          close;
  logic [1:0]    nb;
  logic [7:0]    b0, b1;

  assign b      = body_i.body_byte;
  assign last   = body_i.body_last;
  assign body_i.ready = !fifo_full_i;
  assign accept = body_i.valid && !fifo_full_i;

  assign klen     = (key_len_q > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len_q;
  assign lim      = (LW'(max_len_q) < LW'(MAX_VALUE)) ? LW'(max_len_q) : LW'(MAX_VALUE);
  assign cnt_inc  = (LW + 1)'(cnt_q) + 1'b1;
  assign key_byte = key_chars_q[{3'(kpos_q), 3'b000} +: 8];
  assign hi       = hex_digit(pend_q);
  assign lo       = hex_digit(b);
  assign decoded  = (hi[4] && lo[4]) ? {hi[3:0], lo[3:0]} : 8'h00;

  always_comb begin
    phase_d = phase_q;
    kpos_d  = kpos_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    seen_d  = seen_q;
    close   = 1'b0;
    nb      = 2'd0;
    b0      = 8'h00;
    b1      = 8'h00;

    unique case (phase_q)
      PH_MATCH: begin
        if (b == CH_AMP) begin
          kpos_d = '0;
        end else if (4'(kpos_q) < klen) begin
          if (b == key_byte) kpos_d = kpos_q + 1'b1;
          else               phase_d = PH_SKIP;
        end else if (b == CH_EQ) begin
          seen_d  = 1'b1;
          cnt_d   = '0;
          phase_d = (lim == '0) ? PH_DONE : PH_VALUE;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == CH_AMP) begin
          kpos_d  = '0;
          phase_d = PH_MATCH;
        end
      end
      PH_VALUE, PH_HEX1, PH_HEX2: begin
        if (b == CH_AMP) begin
          close = 1'b1;
        end else begin
          cnt_d = CW'(cnt_inc);
          if (phase_q == PH_VALUE) begin
            if (b == CH_PCT) begin
              phase_d = PH_HEX1;
            end else begin
              nb = 2'd1;
              b0 = plain(b);
            end
          end else if (phase_q == PH_HEX1) begin
            pend_d  = b;
            phase_d = PH_HEX2;
          end else begin
            nb      = 2'd1;
            b0      = decoded;
            phase_d = PH_VALUE;
          end
          if (cnt_inc >= (LW + 1)'(lim)) close = 1'b1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (last && (phase_d == PH_VALUE || phase_d == PH_HEX1 || phase_d == PH_HEX2)) begin
      close = 1'b1;
    end

    // A cut-off escape goes out literally; no byte was emitted on this step then
    if (close) begin
      if (phase_d == PH_HEX1) begin
        nb = 2'd1;
        b0 = CH_PCT;
      end else if (phase_d == PH_HEX2) begin
        nb = 2'd2;
        b0 = CH_PCT;
        b1 = plain(pend_d);
      end
      phase_d = PH_DONE;
    end

    cmd_o.byte0   = b0;
    cmd_o.byte1   = b1;
    cmd_o.n_bytes = nb;
    cmd_o.done    = last;
    cmd_o.found   = seen_d;

    if (last) begin
      phase_d = PH_MATCH;
      kpos_d  = '0;
      cnt_d   = '0;
      pend_d  = 8'h00;
      seen_d  = 1'b0;
    end
  end

  assign push_o = accept && (nb != 2'd0 || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q   <= 4'd4;
      key_chars_q <= '0;
      max_len_q   <= 9'd63;
      phase_q     <= PH_MATCH;
      kpos_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 8'h00;
      seen_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ffe_pkg::CFG_KEY_LENGTH:    key_len_q   <= cfg_data_i[3:0];
          ffe_pkg::CFG_KEY_CHARS:     key_chars_q <= cfg_data_i;
          ffe_pkg::CFG_MAX_VALUE_LEN: max_len_q   <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase_q <= phase_d;
        kpos_q  <= kpos_d;
        cnt_q   <= cnt_d;
        pend_q  <= pend_d;
        seen_q  <= seen_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(kpos_q) <= KEY_BYTES)
    else $error("key position beyond key storage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (phase_q == PH_MATCH && !seen_q && kpos_q == '0))
    else $error("parser not cleared after end of body");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEX2 || phase_q == PH_VALUE || phase_q == PH_HEX1) |-> seen_q)
    else $error("decoding a value without a key match");

endmodule

>>> sv/ffe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ffe_cmd_fifo
// Four-entry command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module ffe_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ffe_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output ffe_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  ffe_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PW + 1)'(DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("pop from empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == {1'b0, wr_q - rd_q} || (count_q == (PW + 1)'(DEPTH) && wr_q == rd_q))
    else $error("queue count out of step with pointers");

endmodule

>>> sv/ffe_back.sv
// ----------------------------------------------------------------------------
// ffe_back
// Emitter: expands each queued command into its results, one per cycle while
// value_o is not held off, through a registered output stage.
// ----------------------------------------------------------------------------
module ffe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ffe_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  ffe_value_if.source   value_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       done_q, found_q;
  logic [1:0] step_q;

  logic       load, take, is_byte;
  logic [1:0] len;
  logic [7:0] sel_byte;

  assign len      = ffe_pkg::cmd_len(head_i);
  assign load     = !valid_q || value_o.ready;
  assign take     = load && !empty_i;
  assign is_byte  = step_q < head_i.n_bytes;
  assign sel_byte = (step_q == 2'd0) ? head_i.byte0 : head_i.byte1;
  assign pop_o    = take && (step_q + 2'd1 == len);

  assign value_o.valid      = valid_q;
  assign value_o.value_byte = byte_q;
  assign value_o.value_done = done_q;
  assign value_o.key_found  = found_q;

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q  <= is_byte ? sel_byte : 8'h00;
      done_q  <= !is_byte;
      found_q <= is_byte ? 1'b0 : head_i.found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 2'd0;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        step_q  <= pop_o ? 2'd0 : step_q + 2'd1;
      end else if (value_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (step_q < len))
    else $error("emitter step beyond command length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && done_q) |-> (byte_q == 8'h00))
    else $error("done result carries a data byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !done_q) |-> !found_q)
    else $error("found flag set on a value byte");

endmodule

>>> sv/form_field_extract_url_decode.sv
// ----------------------------------------------------------------------------
// form_field_extract_url_decode
// Extracts and URL-decodes the value of one configured key from a
// form-encoded body.
// ----------------------------------------------------------------------------
// Usage: body bytes enter on body_i (valid/ready), body_last on the final
// byte. Decoded value bytes leave on value_o; every body closes with one
// transfer carrying value_done = 1 and key_found. Configuration (key length,
// key characters, value length limit) is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle.
// Throughput: one body byte per cycle. The parser stalls only when the
// four-entry command queue is full, which happens when value_o is held off
// or when a byte expands to more than one result (a cut-off escape at the
// end of a value followed by the done transfer gives up to three), since the
// emitter sends one result per cycle.
// Path: a result reaches value_o from its accepted byte through the queue
// write, then the output register.
// Reset: configuration returns to key length 4, key all zero, limit 63; the
// parser waits for the start of a body; queue and output are empty.
// ----------------------------------------------------------------------------
module form_field_extract_url_decode #(
  parameter int unsigned KEY_BYTES = 8,
  parameter int unsigned MAX_VALUE = 511
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ffe_body_if.sink                       body_i,
  ffe_value_if.source                    value_o
);

  ffe_pkg::cmd_t cmd, head;
  logic          push, pop, empty, full;

  ffe_front #(
    .KEY_BYTES (KEY_BYTES),
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .body_i      (body_i),
    .fifo_full_i (full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  ffe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  ffe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .value_o (value_o)
  );

endmodule
